FILE: design/ebalu_pkg.sv
// Shared types and operation codes for the eight-bit ALU with flags.
// No dependencies; used by ebalu_core, eight_bit_alu_with_flags and the testbench.
package ebalu_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 3;
    localparam int unsigned FLAG_W = 4;

    // Flag positions within a flag nibble
    localparam int unsigned FLAG_Z_POS = 3;
    localparam int unsigned FLAG_N_POS = 2;
    localparam int unsigned FLAG_H_POS = 1;
    localparam int unsigned FLAG_C_POS = 0;

    // DAA constants
    localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0]        DAA_LO_LIM = 4'h9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_AND  = 5'd4,
        CMD_XOR  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_CP   = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_RLCA = 5'd10,
        CMD_RRCA = 5'd11,
        CMD_RLA  = 5'd12,
        CMD_RRA  = 5'd13,
        CMD_DAA  = 5'd14,
        CMD_CPL  = 5'd15,
        CMD_SCF  = 5'd16,
        CMD_CCF  = 5'd17,
        CMD_RLC  = 5'd18,
        CMD_RRC  = 5'd19,
        CMD_RL   = 5'd20,
        CMD_RR   = 5'd21,
        CMD_SLA  = 5'd22,
        CMD_SRA  = 5'd23,
        CMD_SWAP = 5'd24,
        CMD_SRL  = 5'd25,
        CMD_BIT  = 5'd26,
        CMD_RES  = 5'd27,
        CMD_SET  = 5'd28
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] operand_a;
        logic [BYTE_W-1:0] operand_b;
        logic [BIT_W-1:0]  bit_index;
        logic [FLAG_W-1:0] flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [BYTE_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
        logic              write_result;
    } t_alu_out;

endpackage

FILE: design/ebalu_core.sv
// Combinational datapath of the eight-bit ALU: result byte, flags, write enable.
// Depends on ebalu_pkg.
module ebalu_core
    import ebalu_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              cin;
    logic              zin;
    logic              nin;
    logic              hin;
    logic              c_use;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        hsum;
    logic [BYTE_W:0]   dif9;
    logic [4:0]        hdif;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] daa_adj;
    logic              daa_c;
    logic [BYTE_W-1:0] r;
    logic              fz;
    logic              fn;
    logic              fh;
    logic              fc;
    logic              z_auto;
    logic              wr;
    logic              keep_flags;

    assign a   = i_op.operand_a;
    assign b   = i_op.operand_b;
    assign cin = i_op.flags_in[FLAG_C_POS];
    assign zin = i_op.flags_in[FLAG_Z_POS];
    assign nin = i_op.flags_in[FLAG_N_POS];
    assign hin = i_op.flags_in[FLAG_H_POS];

    // Carry-in only for the with-carry forms
    assign c_use = ((i_op.command == CMD_ADC) || (i_op.command == CMD_SBC)) ? cin : 1'b0;

    assign sum9 = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, c_use};
    assign hsum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c_use};
    // Borrow out shows as the top bit of the widened difference
    assign dif9 = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, c_use};
    assign hdif = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, c_use};

    assign mask = BYTE_W'(1) << i_op.bit_index;

    always_comb begin
        daa_adj = '0;
        daa_c   = cin;
        if (!nin) begin
            if (cin || (a > DAA_HI_LIM)) begin
                daa_adj = daa_adj | DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            if (hin || (a[3:0] > DAA_LO_LIM)) begin
                daa_adj = daa_adj | DAA_LO_ADJ;
            end
        end else begin
            if (cin) daa_adj = daa_adj | DAA_HI_ADJ;
            if (hin) daa_adj = daa_adj | DAA_LO_ADJ;
        end
    end

    always_comb begin
        r          = a;
        wr         = 1'b1;
        z_auto     = 1'b1;
        keep_flags = 1'b0;
        fz         = zin;
        fn         = 1'b0;
        fh         = 1'b0;
        fc         = 1'b0;
        unique case (t_cmd'(i_op.command))
            CMD_ADD, CMD_ADC: begin
                r  = sum9[BYTE_W-1:0];
                fh = hsum[4];
                fc = sum9[BYTE_W];
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                r  = dif9[BYTE_W-1:0];
                fn = 1'b1;
                fh = hdif[4];
                fc = dif9[BYTE_W];
            end
            CMD_AND: begin r = a & b; fh = 1'b1; end
            CMD_XOR: r = a ^ b;
            CMD_OR:  r = a | b;
            CMD_INC: begin
                r  = a + 8'd1;
                fh = (a[3:0] == 4'hF);
                fc = cin;
            end
            CMD_DEC: begin
                r  = a - 8'd1;
                fn = 1'b1;
                fh = (a[3:0] == 4'h0);
                fc = cin;
            end
            CMD_RLCA: begin r = {a[6:0], a[7]}; fc = a[7]; z_auto = 1'b0; fz = 1'b0; end
            CMD_RRCA: begin r = {a[0], a[7:1]}; fc = a[0]; z_auto = 1'b0; fz = 1'b0; end
            CMD_RLA:  begin r = {a[6:0], cin};  fc = a[7]; z_auto = 1'b0; fz = 1'b0; end
            CMD_RRA:  begin r = {cin, a[7:1]};  fc = a[0]; z_auto = 1'b0; fz = 1'b0; end
            CMD_DAA: begin
                r  = nin ? (a - daa_adj) : (a + daa_adj);
                fn = nin;
                fc = daa_c;
            end
            CMD_CPL: begin
                r      = ~a;
                z_auto = 1'b0;
                fn     = 1'b1;
                fh     = 1'b1;
                fc     = cin;
            end
            CMD_SCF: begin z_auto = 1'b0; fc = 1'b1; end
            CMD_CCF: begin z_auto = 1'b0; fc = ~cin; end
            CMD_RLC:  begin r = {a[6:0], a[7]};  fc = a[7]; end
            CMD_RRC:  begin r = {a[0], a[7:1]};  fc = a[0]; end
            CMD_RL:   begin r = {a[6:0], cin};   fc = a[7]; end
            CMD_RR:   begin r = {cin, a[7:1]};   fc = a[0]; end
            CMD_SLA:  begin r = {a[6:0], 1'b0};  fc = a[7]; end
            CMD_SRA:  begin r = {a[7], a[7:1]};  fc = a[0]; end
            CMD_SWAP: r = {a[3:0], a[7:4]};
            CMD_SRL:  begin r = {1'b0, a[7:1]};  fc = a[0]; end
            CMD_BIT: begin
                z_auto = 1'b0;
                fz     = ((a & mask) == '0);
                fh     = 1'b1;
                fc     = cin;
            end
            CMD_RES: begin r = a & ~mask; keep_flags = 1'b1; end
            CMD_SET: begin r = a | mask;  keep_flags = 1'b1; end
            default: keep_flags = 1'b1;
        endcase

        // Compare, bit test and unused codes leave the target untouched
        if ((i_op.command == CMD_CP) || (i_op.command == CMD_BIT) ||
            (i_op.command > CMD_SET)) begin
            wr = 1'b0;
        end
        if (z_auto) fz = (r == '0);
    end

    assign o_res.result       = ((i_op.command == CMD_CP) || !wr) ? a : r;
    assign o_res.flags_out    = keep_flags ? i_op.flags_in : {fz, fn, fh, fc};
    assign o_res.write_result = wr;

endmodule

FILE: design/eight_bit_alu_with_flags.sv
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
// Depends on ebalu_pkg and ebalu_core.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+--------------
//  s_axis   | in  | operand_a[7:0] operand_b[15:8]              | command[4:0]
//           |     | bit_index[18:16] flags_in[22:19] pad[23]    |
//  m_axis   | out | result[7:0] flags_out[11:8] pad[15:12]      | write_result
//
// An accepted beat is held in one register in front of the datapath and its
// result in one register behind it. One beat is taken every cycle while
// the result side keeps up; the whole operation is one pass through ebalu_core.
// Each stage holds while its successor is full and stalled, so a stalled
// output backs up through the input stage to s_axis_tready.
// Synchronous active-low reset clears only the stage valid flags.
module eight_bit_alu_with_flags
    import ebalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // operand_a, operand_b, bit_index, flags_in, pad
    input  logic [4:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // result, flags_out, pad
    output logic        m_axis_tuser   // write_result
);

    logic     r_in_valid;
    logic     n_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_out r_out;
    t_alu_out core_res;
    logic     out_adv;   // result stage free to load
    logic     in_take;   // input beat accepted this cycle

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) n_in_valid = s_axis_tvalid;
        n_out_valid = r_out_valid;
        if (out_adv) n_out_valid = r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command   <= s_axis_tuser;
            r_in.operand_a <= s_axis_tdata[7:0];
            r_in.operand_b <= s_axis_tdata[15:8];
            r_in.bit_index <= s_axis_tdata[18:16];
            r_in.flags_in  <= s_axis_tdata[22:19];
        end
        if (out_adv && r_in_valid) begin
            r_out <= core_res;
        end
    end

    ebalu_core u_core (
        .i_op  (r_in),
        .o_res (core_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.flags_out, r_out.result};
    assign m_axis_tuser  = r_out.write_result;

endmodule

FILE: design/ebalu_chk.sv
// Port-level checker for eight_bit_alu_with_flags, attached by bind.
// No package dependencies.
module ebalu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic s_beat;
    assign s_beat = s_axis_tvalid && s_axis_tready;

    // Reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present after reset");

    // A result beat that newly appears always has a matching earlier input beat
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_beat, 2))
        else $error("result beat without matching input beat");

    // An input beat followed by a ready result side yields a valid result beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result beat late");

    // Stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind eight_bit_alu_with_flags ebalu_chk u_ebalu_chk (.*);

FILE: tb/tb_eight_bit_alu_with_flags.sv
`timescale 1ns / 1ps
// Self-checking testbench for eight_bit_alu_with_flags: a table of corner beats, then random
// beats under four handshake mixes, every result beat checked against a typed row or a behavioural ALU.
// Depends on ebalu_pkg and the design sources; needs no files or arguments.
module tb_eight_bit_alu_with_flags;
    import ebalu_pkg::*;

    localparam int unsigned CLK_HALF    = 4;     // 8 ns period
    localparam int unsigned RESET_LEN   = 9;
    localparam int unsigned RAND_BEATS  = 2000;
    localparam int unsigned HOLD_AT     = 100;   // beats in before the long output hold-off
    localparam int unsigned HOLD_LEN    = 80;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned TAIL_CYCLES = 8;     // margin before the final count of missing beats

    // Command codes beyond SET: no operation, flags pass through, nothing written
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 5'd29;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 5'd31;

    // One row of the corner table; want is only meaningful when typed is set
    typedef struct {
        t_alu_in  stim;
        bit       typed;
        t_alu_out want;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // operand_a, operand_b, bit_index, flags_in, pad
    logic [4:0]  s_axis_tuser  = '0;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // result, flags_out, pad
    logic        m_axis_tuser;           // write_result

    t_alu_out    pending_results[$];     // expected result beats, oldest first
    int unsigned beats_in      = 0;
    int unsigned beats_out     = 0;
    int unsigned faults        = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit [31:0]   cmds_seen     = '0;

    eight_bit_alu_with_flags DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioural ALU: result byte, Z N H C and write enable for one beat
    // ------------------------------------------------------------------
    function automatic t_alu_out alu_predict(input t_alu_in x);
        t_alu_out   y;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] mask;
        logic [7:0] adj;
        logic [8:0] wide;
        logic [4:0] nib;
        logic       cin;
        logic       zin;
        logic       nin;
        logic       hin;
        logic       cy;
        a    = x.operand_a;
        b    = x.operand_b;
        cin  = x.flags_in[FLAG_C_POS];
        zin  = x.flags_in[FLAG_Z_POS];
        nin  = x.flags_in[FLAG_N_POS];
        hin  = x.flags_in[FLAG_H_POS];
        mask = 8'h01 << x.bit_index;
        y.result       = a;
        y.flags_out    = x.flags_in;
        y.write_result = 1'b1;
        case (x.command)
            CMD_ADD, CMD_ADC: begin
                cy   = (x.command == CMD_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + cy;
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + cy;
                y.result    = wide[7:0];
                y.flags_out = {wide[7:0] == 8'h00, 1'b0, nib[4], wide[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                cy   = (x.command == CMD_SBC) ? cin : 1'b0;
                wide = {1'b0, a} - {1'b0, b} - cy;
                y.result    = wide[7:0];
                y.flags_out = {wide[7:0] == 8'h00, 1'b1,
                               ({1'b0, b[3:0]} + cy) > {1'b0, a[3:0]},
                               ({1'b0, b} + cy) > {1'b0, a}};
                // compare keeps the accumulator and writes nothing back
                if (x.command == CMD_CP) begin
                    y.result       = a;
                    y.write_result = 1'b0;
                end
            end
            CMD_AND: begin
                y.result    = a & b;
                y.flags_out = {y.result == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            CMD_XOR: begin
                y.result    = a ^ b;
                y.flags_out = {y.result == 8'h00, 3'b000};
            end
            CMD_OR: begin
                y.result    = a | b;
                y.flags_out = {y.result == 8'h00, 3'b000};
            end
            // INC and DEC leave carry alone
            CMD_INC: begin
                y.result    = a + 8'd1;
                y.flags_out = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
            end
            CMD_DEC: begin
                y.result    = a - 8'd1;
                y.flags_out = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
            end
            // accumulator rotates always clear Z
            CMD_RLCA: begin
                y.result    = {a[6:0], a[7]};
                y.flags_out = {3'b000, a[7]};
            end
            CMD_RRCA: begin
                y.result    = {a[0], a[7:1]};
                y.flags_out = {3'b000, a[0]};
            end
            CMD_RLA: begin
                y.result    = {a[6:0], cin};
                y.flags_out = {3'b000, a[7]};
            end
            CMD_RRA: begin
                y.result    = {cin, a[7:1]};
                y.flags_out = {3'b000, a[0]};
            end
            CMD_DAA: begin
                adj = 8'h00;
                cy  = cin;
                if (!nin) begin
                    if (cy || a > DAA_HI_LIM) begin
                        adj = adj | DAA_HI_ADJ;
                        cy  = 1'b1;
                    end
                    if (hin || a[3:0] > DAA_LO_LIM) adj = adj | DAA_LO_ADJ;
                    y.result = a + adj;
                end else begin
                    if (cy) adj = adj | DAA_HI_ADJ;
                    if (hin) adj = adj | DAA_LO_ADJ;
                    y.result = a - adj;
                end
                y.flags_out = {y.result == 8'h00, nin, 1'b0, cy};
            end
            CMD_CPL: begin
                y.result    = ~a;
                y.flags_out = {zin, 1'b1, 1'b1, cin};
            end
            CMD_SCF: y.flags_out = {zin, 1'b0, 1'b0, 1'b1};
            CMD_CCF: y.flags_out = {zin, 1'b0, 1'b0, ~cin};
            CMD_RLC: begin
                y.result    = {a[6:0], a[7]};
                y.flags_out = {y.result == 8'h00, 2'b00, a[7]};
            end
            CMD_RRC: begin
                y.result    = {a[0], a[7:1]};
                y.flags_out = {y.result == 8'h00, 2'b00, a[0]};
            end
            CMD_RL: begin
                y.result    = {a[6:0], cin};
                y.flags_out = {y.result == 8'h00, 2'b00, a[7]};
            end
            CMD_RR: begin
                y.result    = {cin, a[7:1]};
                y.flags_out = {y.result == 8'h00, 2'b00, a[0]};
            end
            CMD_SLA: begin
                y.result    = {a[6:0], 1'b0};
                y.flags_out = {y.result == 8'h00, 2'b00, a[7]};
            end
            CMD_SRA: begin
                y.result    = {a[7], a[7:1]};
                y.flags_out = {y.result == 8'h00, 2'b00, a[0]};
            end
            CMD_SWAP: begin
                y.result    = {a[3:0], a[7:4]};
                y.flags_out = {y.result == 8'h00, 3'b000};
            end
            CMD_SRL: begin
                y.result    = {1'b0, a[7:1]};
                y.flags_out = {y.result == 8'h00, 2'b00, a[0]};
            end
            CMD_BIT: begin
                y.write_result = 1'b0;
                y.flags_out    = {(a & mask) == 8'h00, 1'b0, 1'b1, cin};
            end
            CMD_RES: y.result = a & ~mask;
            CMD_SET: y.result = a | mask;
            default: y.write_result = 1'b0;   // spare codes: pass-through, no write
        endcase
        return y;
    endfunction

    function automatic t_row corner_row(input logic [CMD_W-1:0] cmd, input logic [7:0] a,
                                        input logic [7:0] b, input logic [2:0] bi,
                                        input logic [3:0] f, input bit typed,
                                        input logic [7:0] r, input logic [3:0] fo,
                                        input logic wr);
        t_row row;
        row.stim.command        = cmd;
        row.stim.operand_a      = a;
        row.stim.operand_b      = b;
        row.stim.bit_index      = bi;
        row.stim.flags_in       = f;
        row.typed               = typed;
        row.want.result         = r;
        row.want.flags_out      = fo;
        row.want.write_result   = wr;
        return row;
    endfunction

    // Mostly uniform bytes, with a share of carry, half-carry and BCD boundaries
    function automatic logic [7:0] random_byte();
        if ($urandom_range(3) != 0) return 8'($urandom_range(255));
        case ($urandom_range(8))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h0F;
            3:       return 8'h10;
            4:       return 8'h7F;
            5:       return 8'h80;
            6:       return 8'h99;
            7:       return 8'h9A;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic t_alu_in random_item();
        t_alu_in x;
        if ($urandom_range(39) == 0)
            x.command = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        else
            x.command = CMD_W'($urandom_range(CMD_SET, CMD_ADD));
        x.operand_a = random_byte();
        x.operand_b = random_byte();
        x.bit_index = BIT_W'($urandom_range(7));
        x.flags_in  = FLAG_W'($urandom_range(15));
        return x;
    endfunction

    // Offer one beat from a falling edge; returns on the falling edge after acceptance.
    // tvalid is left high so back-to-back beats never toggle it within one step.
    task automatic offer_beat(input t_alu_in x, input bit typed, input t_alu_out want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, x.flags_in, x.bit_index, x.operand_b, x.operand_a};
        s_axis_tuser  <= x.command;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(typed ? want : alu_predict(x));
        beats_in++;
        cmds_seen[x.command] = 1'b1;
        @(negedge i_clk);
    endtask

    // Sender goes quiet until every expected beat is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, corner table, then four handshake mixes
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row        corner_rows[$];
        t_alu_out    none;
        int unsigned mix;
        none = '0;

        // cmd, a, b, bit, flags in, typed, result, flags out, write
        corner_rows.push_back(corner_row(CMD_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1011, 1'b1));
        corner_rows.push_back(corner_row(CMD_ADD,  8'h3A, 8'hC6, 3'd0, 4'b0101, 0,
                                         8'h00, 4'b0000, 1'b0));
        corner_rows.push_back(corner_row(CMD_ADC,  8'hFF, 8'h00, 3'd0, 4'b0001, 1,
                                         8'h00, 4'b1011, 1'b1));
        corner_rows.push_back(corner_row(CMD_SUB,  8'h00, 8'h01, 3'd0, 4'b0000, 1,
                                         8'hFF, 4'b0111, 1'b1));
        corner_rows.push_back(corner_row(CMD_SBC,  8'h10, 8'h0F, 3'd0, 4'b0001, 1,
                                         8'h00, 4'b1110, 1'b1));
        corner_rows.push_back(corner_row(CMD_AND,  8'hF0, 8'h0F, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1010, 1'b1));
        corner_rows.push_back(corner_row(CMD_XOR,  8'hFF, 8'hFF, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1000, 1'b1));
        corner_rows.push_back(corner_row(CMD_OR,   8'h00, 8'h00, 3'd0, 4'b1111, 1,
                                         8'h00, 4'b1000, 1'b1));
        // compare: accumulator back unchanged, no write
        corner_rows.push_back(corner_row(CMD_CP,   8'h42, 8'h42, 3'd0, 4'b0000, 1,
                                         8'h42, 4'b1100, 1'b0));
        corner_rows.push_back(corner_row(CMD_INC,  8'hFF, 8'h00, 3'd0, 4'b0001, 1,
                                         8'h00, 4'b1011, 1'b1));
        corner_rows.push_back(corner_row(CMD_DEC,  8'h00, 8'h00, 3'd0, 4'b0000, 1,
                                         8'hFF, 4'b0110, 1'b1));
        corner_rows.push_back(corner_row(CMD_RLCA, 8'h80, 8'h00, 3'd0, 4'b1000, 1,
                                         8'h01, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_RRCA, 8'h01, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h80, 4'b0001, 1'b1));
        // zero result, yet Z stays clear on the accumulator rotate
        corner_rows.push_back(corner_row(CMD_RLA,  8'h80, 8'h00, 3'd0, 4'b1000, 1,
                                         8'h00, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_RRA,  8'h01, 8'h00, 3'd0, 4'b0001, 1,
                                         8'h80, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1001, 1'b1));
        // DAA after subtraction with both adjusts pending
        corner_rows.push_back(corner_row(CMD_DAA,  8'h00, 8'h00, 3'd0, 4'b0111, 0,
                                         8'h00, 4'b0000, 1'b0));
        corner_rows.push_back(corner_row(CMD_CPL,  8'h00, 8'h00, 3'd0, 4'b1000, 1,
                                         8'hFF, 4'b1110, 1'b1));
        corner_rows.push_back(corner_row(CMD_SCF,  8'h55, 8'h00, 3'd0, 4'b1110, 1,
                                         8'h55, 4'b1001, 1'b1));
        corner_rows.push_back(corner_row(CMD_CCF,  8'h3C, 8'h00, 3'd0, 4'b1001, 1,
                                         8'h3C, 4'b1000, 1'b1));
        corner_rows.push_back(corner_row(CMD_RLC,  8'h00, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1000, 1'b1));
        corner_rows.push_back(corner_row(CMD_RRC,  8'h01, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h80, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_RL,   8'h80, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1001, 1'b1));
        corner_rows.push_back(corner_row(CMD_RR,   8'h01, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1001, 1'b1));
        corner_rows.push_back(corner_row(CMD_SLA,  8'hFF, 8'h00, 3'd0, 4'b0000, 1,
                                         8'hFE, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_SRA,  8'h81, 8'h00, 3'd0, 4'b0000, 1,
                                         8'hC0, 4'b0001, 1'b1));
        corner_rows.push_back(corner_row(CMD_SWAP, 8'hF0, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h0F, 4'b0000, 1'b1));
        corner_rows.push_back(corner_row(CMD_SRL,  8'h01, 8'h00, 3'd0, 4'b0000, 1,
                                         8'h00, 4'b1001, 1'b1));
        // bit test: byte back unchanged, no write
        corner_rows.push_back(corner_row(CMD_BIT,  8'h7F, 8'h00, 3'd7, 4'b0001, 1,
                                         8'h7F, 4'b1011, 1'b0));
        corner_rows.push_back(corner_row(CMD_RES,  8'hFF, 8'h00, 3'd0, 4'b1111, 1,
                                         8'hFE, 4'b1111, 1'b1));
        corner_rows.push_back(corner_row(CMD_SET,  8'h00, 8'h00, 3'd7, 4'b0000, 1,
                                         8'h80, 4'b0000, 1'b1));
        corner_rows.push_back(corner_row(CMD_SPARE_HI, 8'hAB, 8'hCD, 3'd5, 4'b0101, 1,
                                         8'hAB, 4'b0101, 1'b0));

        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (corner_rows[i])
            offer_beat(corner_rows[i].stim, corner_rows[i].typed, corner_rows[i].want);
        wait_drained();

        // mix 0: free running (long hold-off lands here); 1: sender gaps;
        // 2: receiver stalls; 3: both
        for (mix = 0; mix < 4; mix++) begin
            case (mix)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 46; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            repeat (RAND_BEATS / 4) offer_beat(random_item(), 1'b0, none);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            faults += pending_results.size();
            $display("%0d expected result beats never arrived", pending_results.size());
        end

        $display("Run covered %0d operand beats and %0d result beats, %0d of 32 command codes,",
                 beats_in, beats_out, $countones(cmds_seen));
        $display("four handshake mixes and a %0d-cycle output hold-off; %0d faults",
                 HOLD_LEN, faults);
        if (faults == 0) begin
            $display("tb_eight_bit_alu_with_flags passed");
        end else begin
            $display("tb_eight_bit_alu_with_flags failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls plus one long hold-off, counted here, so
    // the pipeline fills and s_axis_tready drops while beats are offered
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_drain
        if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Each accepted result beat against the oldest expectation, field by field
    always @(posedge i_clk) begin : result_check
        t_alu_out got;
        t_alu_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result       = m_axis_tdata[7:0];
            got.flags_out    = m_axis_tdata[11:8];
            got.write_result = m_axis_tuser;
            beats_out++;
            if (pending_results.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("result beat %0d unexpected: result %02h flags %04b write %0b",
                             beats_out, got.result, got.flags_out, got.write_result);
            end else begin
                want = pending_results.pop_front();
                if (got.result !== want.result || got.flags_out !== want.flags_out ||
                        got.write_result !== want.write_result) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("result beat %0d: expected %02h/%04b/%0b, got %02h/%04b/%0b",
                                 beats_out, want.result, want.flags_out, want.write_result,
                                 got.result, got.flags_out, got.write_result);
                end
            end
        end
    end

    // Watchdog: a correct run needs well under a tenth of this
    initial begin : watchdog
        #2_000_000;
        $display("tb_eight_bit_alu_with_flags failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/ebalu_pkg.sv
design/ebalu_core.sv
design/eight_bit_alu_with_flags.sv
design/ebalu_chk.sv
tb/tb_eight_bit_alu_with_flags.sv
